@@ rtl/core/skpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpc_pkg: shared types and constants of the soft-knee peak compressor
// Holds register codes, control states, fixed-point constants and the
// exponent table used by the gain unit.
// ----------------------------------------------------------------------------
package skpc_pkg;

  // dB floor (100 dB in Q8.8) and conversion factors
  localparam logic [14:0] FloorDb   = 15'd25600;
  localparam logic [18:0] DbPerLog2 = 19'd394566;
  localparam logic [21:0] Log2PerDb = 22'd2786635;

  // configuration port widths
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 24;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ENABLE        = 3'd0,
    REG_THRESHOLD_DB  = 3'd1,
    REG_SLOPE         = 3'd2,
    REG_MAKEUP_GAIN   = 3'd3,
    REG_KNEE_DB       = 3'd4,
    REG_KNEE_RECIP    = 3'd5,
    REG_ATTACK_COEFF  = 3'd6,
    REG_RELEASE_COEFF = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        enable;
    logic [14:0] threshold_db;   // signed Q7.8
    logic [15:0] slope;
    logic [15:0] makeup_gain;
    logic [12:0] knee_db;
    logic [23:0] knee_recip;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEAK,
    ST_LEVEL,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_KNEE,
    ST_KNEE_SQ,
    ST_KNEE_T,
    ST_KNEE_R,
    ST_GAIN_GO,
    ST_GAIN,
    ST_APPLY,
    ST_DONE
  } state_e;

  // 2^(-2^-k) in Q1.30 for k = 1..16; entry 0 holds 1.0
  typedef logic [30:0] exp_tab_t [17];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic exp_tab_t build_exp_table();
    exp_tab_t    t;
    logic [63:0] v;
    t[0] = 31'h4000_0000;
    v    = floor_sqrt(64'h0800_0000_0000_0000);
    t[1] = v[30:0];
    for (int k = 2; k <= 16; k++) begin
      v    = floor_sqrt({3'b0, t[k-1], 30'b0});
      t[k] = v[30:0];
    end
    return t;
  endfunction

  localparam exp_tab_t ExpTable = build_exp_table();

endpackage
`default_nettype wire

@@ rtl/core/skpc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpc_if: channel interfaces of the compressor
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface skpc_in_if #(parameter int unsigned SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  modport source(output valid, sample_left, sample_right, input ready);
  modport sink(input valid, sample_left, sample_right, output ready);
endinterface

interface skpc_out_if #(parameter int unsigned SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic [14:0]                   reduction_db;
  modport source(output valid, out_left, out_right, reduction_db, input ready);
  modport sink(input valid, out_left, out_right, reduction_db, output ready);
endinterface

interface skpc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [skpc_pkg::CfgIdxBits-1:0]      index;
  logic [skpc_pkg::CfgDataBits-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/skpc_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpc_lane: per-channel lane
// Magnitude for the peak detector and gained, rounded, saturated sample.
// ----------------------------------------------------------------------------
module skpc_lane #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [29:0]            gain_i,     // Q2.28
  output logic        [SAMPLE_BITS-1:0] mag_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);
  localparam int unsigned PW = SAMPLE_BITS + 30;
  localparam int unsigned QW = PW - 27;
  localparam logic [QW-1:0] NegLim = QW'(1) << (SAMPLE_BITS - 1);
  localparam logic [QW-1:0] PosLim = NegLim - QW'(1);

  logic [PW-1:0] prod;
  logic [PW:0]   sum;
  logic [QW-1:0] q;
  logic [QW-1:0] qs;

  // magnitude; the most negative code fits as unsigned
  assign mag_o = sample_i[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_i)
                                         : SAMPLE_BITS'(sample_i);

  // round half away from zero by working on the magnitude
  assign prod = PW'(mag_o) * PW'(gain_i);
  assign sum  = {1'b0, prod} + (PW + 1)'(28'h800_0000);
  assign q    = sum[PW:28];

  always_comb begin
    if (sample_i[SAMPLE_BITS-1]) begin
      qs       = (q > NegLim) ? NegLim : q;
      result_o = -$signed(qs[SAMPLE_BITS-1:0]);
    end else begin
      qs       = (q > PosLim) ? PosLim : q;
      result_o = $signed(qs[SAMPLE_BITS-1:0]);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/skpc_level.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpc_level: peak to dB converter
// log2 by 16 rounds of squaring on one multiplier, then scaling to dB Q8.8.
// ----------------------------------------------------------------------------
module skpc_level #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] peak_i,
  output logic                   done_o,
  output logic signed [15:0]     level_o
);
  localparam int unsigned EW = $clog2(SAMPLE_BITS);
  localparam int unsigned LW = EW + 16;
  localparam logic [LW-1:0] Full = LW'(SAMPLE_BITS - 1) << 16;

  logic          busy_q;
  logic [4:0]    cnt_q;
  logic          done_q;
  logic [30:0]   m_q;
  logic [EW-1:0] e_q;
  logic [15:0]   frac_q;
  logic          zero_q;
  logic [LW-1:0] dist_q;
  logic signed [15:0] level_q;

  logic [EW-1:0]          e_c;
  logic [SAMPLE_BITS+29:0] norm_c;
  logic [61:0]            sq_c;
  logic [LW-1:0]          lg_c;
  logic [39:0]            db_c;
  logic [15:0]            mag_c;

  // leading one position
  always_comb begin
    e_c = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (peak_i[i]) e_c = EW'(i);
    end
  end

  // mantissa in [2^30, 2^31)
  assign norm_c = {peak_i, 30'b0} >> e_c;
  assign sq_c   = 62'(m_q) * 62'(m_q);
  assign lg_c   = {e_q, frac_q};
  assign db_c   = 40'(dist_q) * 40'(skpc_pkg::DbPerLog2) + 40'h80_0000;
  assign mag_c  = (db_c[39:24] > 16'(skpc_pkg::FloorDb)) ? 16'(skpc_pkg::FloorDb)
                                                       : db_c[39:24];

  // sequencer: load, 16 squarings, distance, scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd17) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q    <= norm_c[30:0];
      e_q    <= e_c;
      frac_q <= '0;
      zero_q <= (peak_i == '0);
    end else if (busy_q) begin
      if (cnt_q < 5'd16) begin
        if (sq_c[61]) begin
          m_q    <= sq_c[61:31];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q    <= sq_c[60:30];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end else if (cnt_q == 5'd16) begin
        dist_q <= (lg_c >= Full) ? '0 : (Full - lg_c);
      end else begin
        level_q <= zero_q ? -$signed(16'(skpc_pkg::FloorDb)) : -$signed(mag_c);
      end
    end
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule
`default_nettype wire

@@ rtl/core/skpc_exp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpc_exp: reduction to linear gain
// dB to log2 exponent, 16 table multiplies for the fraction, shift for the
// integer part, then the makeup gain. Result is Q2.28.
// ----------------------------------------------------------------------------
module skpc_exp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [14:0] red_i,
  input  logic [15:0] makeup_i,
  output logic        done_o,
  output logic [29:0] gain_o
);
  logic        busy_q;
  logic [4:0]  k_q;
  logic        done_q;
  logic [4:0]  whole_q;
  logic [15:0] frac_q;
  logic [30:0] g_q;
  logic [29:0] gain_q;

  logic [36:0] ex_c;
  logic [61:0] gp_c;
  logic [30:0] gs_c;
  logic [46:0] gm_c;

  assign ex_c = 37'(red_i) * 37'(skpc_pkg::Log2PerDb) + 37'd32768;
  assign gp_c = 62'(g_q) * 62'(skpc_pkg::ExpTable[k_q]);
  assign gs_c = g_q >> whole_q;
  assign gm_c = 47'(gs_c) * 47'(makeup_i);

  // step counter: k = 1..16 multiply, 17 finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= 5'd1;
      end else if (busy_q) begin
        k_q <= k_q + 5'd1;
        if (k_q == 5'd17) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      whole_q <= ex_c[36:32] | 5'(ex_c[36:16] >> 16);
      frac_q  <= ex_c[31:16];
      g_q     <= 31'h4000_0000;
    end else if (busy_q) begin
      if (k_q <= 5'd16) begin
        if (frac_q[15]) g_q <= gp_c[60:30];
        frac_q <= {frac_q[14:0], 1'b0};
      end else begin
        gain_q <= gm_c[45:16];
      end
    end
  end

  assign done_o = done_q;
  assign gain_o = gain_q;

endmodule
`default_nettype wire

@@ rtl/core/soft_knee_peak_compressor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_knee_peak_compressor_top: feedforward soft-knee peak compressor
// Linked-peak detector in dB, one-pole dB envelope, soft-knee curve and
// per-channel gain with makeup, one stereo frame per beat.
// ----------------------------------------------------------------------------
// One frame is in flight at a time. With enable set a frame passes from input
// beat to result beat through peak load; the log2 of the peak, by 16 squaring
// rounds on one multiplier, then distance and scaling to dB; two envelope
// steps; the knee decision (three more steps inside the knee); gain start; the
// gain, by 16 table multiplies on another multiplier, then the makeup gain;
// lane apply; and the output load. With enable clear a frame goes straight to
// the output load and the envelope holds. The result sits in an output
// register, so the next input beat is taken while a result waits; that frame
// then stalls in its last step until the register is read. Configuration
// writes are taken every cycle and must only be made while the block is idle.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module soft_knee_peak_compressor_top #(
  parameter int unsigned CHANNELS    = 2,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skpc_in_if.sink     in_ch,
  skpc_out_if.source  out_ch,
  skpc_cfg_if.sink    cfg_ch
);
  localparam int unsigned SB = SAMPLE_BITS;

  skpc_pkg::state_e state_q, state_d;
  skpc_pkg::cfg_t   cfg_q;

  logic signed [SB-1:0] samp_q [2];
  logic signed [SB-1:0] res_q  [2];
  logic signed [15:0]   env_q;
  logic [32:0]          envprod_q;
  logic                 envneg_q;
  logic [13:0]          x2_q;
  logic [27:0]          sq_q;
  logic [27:0]          t_q;
  logic [14:0]          red_q;
  logic                 out_valid_q;
  logic signed [SB-1:0] out_left_q;
  logic signed [SB-1:0] out_right_q;
  logic [14:0]          out_red_q;

  logic                 in_acc;
  logic                 out_load;
  logic                 level_start;
  logic                 exp_start;
  logic                 level_done;
  logic                 exp_done;
  logic signed [15:0]   level_w;
  logic [29:0]          gain_w;
  logic [SB-1:0]        mag_w      [2];
  logic signed [SB-1:0] lane_res_w [2];
  logic [SB-1:0]        peak_w;

  logic signed [16:0] diff_w;
  logic [15:0]        coeff_w;
  logic [15:0]        dmag_w;
  logic [32:0]        envprod_w;
  logic [33:0]        step_sum_w;
  logic [15:0]        step_w;
  logic signed [16:0] over_w;
  logic signed [17:0] twice_w;
  logic signed [17:0] kn_w;
  logic signed [17:0] xs_w;
  logic               below_w;
  logic               above_w;
  logic [32:0]        ap_w;
  logic [43:0]        tp_w;
  logic [52:0]        rp_w;

  function automatic logic [14:0] sat_red(input logic [26:0] v);
    return (v > 27'(skpc_pkg::FloorDb)) ? skpc_pkg::FloorDb : v[14:0];
  endfunction

  // lanes
  for (genvar i = 0; i < 2; i++) begin : g_lane
    if (i < CHANNELS) begin : g_on
      skpc_lane #(.SAMPLE_BITS(SB)) u_lane (
        .sample_i (samp_q[i]),
        .gain_i   (gain_w),
        .mag_o    (mag_w[i]),
        .result_o (lane_res_w[i])
      );
    end else begin : g_off
      assign mag_w[i]      = '0;
      assign lane_res_w[i] = '0;
    end
  end

  // merge: linked peak
  always_comb begin
    peak_w = mag_w[0];
    if (mag_w[1] > peak_w) peak_w = mag_w[1];
  end

  skpc_level #(.SAMPLE_BITS(SB)) u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (level_start),
    .peak_i  (peak_w),
    .done_o  (level_done),
    .level_o (level_w)
  );

  skpc_exp u_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (exp_start),
    .red_i    (red_q),
    .makeup_i (cfg_q.makeup_gain),
    .done_o   (exp_done),
    .gain_o   (gain_w)
  );

  // envelope arithmetic
  assign diff_w     = {level_w[15], level_w} - {env_q[15], env_q};
  assign coeff_w    = (level_w > env_q) ? cfg_q.attack_coeff : cfg_q.release_coeff;
  assign dmag_w     = diff_w[16] ? 16'(-diff_w) : diff_w[15:0];
  assign envprod_w  = 33'(17'h1_0000 - {1'b0, coeff_w}) * 33'(dmag_w);
  assign step_sum_w = {1'b0, envprod_q} + 34'd65535;
  assign step_w     = step_sum_w[31:16];

  // knee arithmetic
  assign over_w  = {env_q[15], env_q} - {{2{cfg_q.threshold_db[14]}}, cfg_q.threshold_db};
  assign twice_w = {over_w, 1'b0};
  assign kn_w    = {5'b0, cfg_q.knee_db};
  assign below_w = (twice_w <= -kn_w);
  assign above_w = (twice_w >= kn_w);
  assign xs_w    = twice_w + kn_w;
  assign ap_w    = 33'(over_w[15:0]) * 33'(cfg_q.slope) + 33'd32768;
  assign tp_w    = 44'(sq_q) * 44'(cfg_q.slope);
  assign rp_w    = 53'(t_q) * 53'(cfg_q.knee_recip) + 53'h200_0000;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_q == skpc_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skpc_pkg::ST_IDLE:
        if (in_acc) state_d = cfg_q.enable ? skpc_pkg::ST_PEAK : skpc_pkg::ST_DONE;
      skpc_pkg::ST_PEAK:    state_d = skpc_pkg::ST_LEVEL;
      skpc_pkg::ST_LEVEL:   if (level_done) state_d = skpc_pkg::ST_ENV_MUL;
      skpc_pkg::ST_ENV_MUL: state_d = skpc_pkg::ST_ENV_UPD;
      skpc_pkg::ST_ENV_UPD: state_d = skpc_pkg::ST_KNEE;
      skpc_pkg::ST_KNEE:
        state_d = (below_w || above_w) ? skpc_pkg::ST_GAIN_GO : skpc_pkg::ST_KNEE_SQ;
      skpc_pkg::ST_KNEE_SQ: state_d = skpc_pkg::ST_KNEE_T;
      skpc_pkg::ST_KNEE_T:  state_d = skpc_pkg::ST_KNEE_R;
      skpc_pkg::ST_KNEE_R:  state_d = skpc_pkg::ST_GAIN_GO;
      skpc_pkg::ST_GAIN_GO: state_d = skpc_pkg::ST_GAIN;
      skpc_pkg::ST_GAIN:    if (exp_done) state_d = skpc_pkg::ST_APPLY;
      skpc_pkg::ST_APPLY:   state_d = skpc_pkg::ST_DONE;
      skpc_pkg::ST_DONE:    if (out_load) state_d = skpc_pkg::ST_IDLE;
      default:              state_d = skpc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_q == skpc_pkg::ST_IDLE);
    level_start = (state_q == skpc_pkg::ST_PEAK);
    exp_start   = (state_q == skpc_pkg::ST_GAIN_GO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.threshold_db  <= 15'h7A00;
      cfg_q.slope         <= 16'd0;
      cfg_q.makeup_gain   <= 16'd16384;
      cfg_q.knee_db       <= 13'd1536;
      cfg_q.knee_recip    <= 24'd5461;
      cfg_q.attack_coeff  <= 16'd65365;
      cfg_q.release_coeff <= 16'd65526;
    end else if (cfg_ch.valid) begin
      unique case (skpc_pkg::reg_idx_e'(cfg_ch.index))
        skpc_pkg::REG_ENABLE:        cfg_q.enable        <= cfg_ch.data[0];
        skpc_pkg::REG_THRESHOLD_DB:  cfg_q.threshold_db  <= cfg_ch.data[14:0];
        skpc_pkg::REG_SLOPE:         cfg_q.slope         <= cfg_ch.data[15:0];
        skpc_pkg::REG_MAKEUP_GAIN:   cfg_q.makeup_gain   <= cfg_ch.data[15:0];
        skpc_pkg::REG_KNEE_DB:       cfg_q.knee_db       <= cfg_ch.data[12:0];
        skpc_pkg::REG_KNEE_RECIP:    cfg_q.knee_recip    <= cfg_ch.data[23:0];
        skpc_pkg::REG_ATTACK_COEFF:  cfg_q.attack_coeff  <= cfg_ch.data[15:0];
        skpc_pkg::REG_RELEASE_COEFF: cfg_q.release_coeff <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= -$signed(16'(skpc_pkg::FloorDb));
    end else if (state_q == skpc_pkg::ST_ENV_UPD) begin
      env_q <= envneg_q ? env_q - $signed(step_w) : env_q + $signed(step_w);
    end
  end

  // frame datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      skpc_pkg::ST_IDLE:
        if (in_acc) begin
          samp_q[0] <= in_ch.sample_left;
          samp_q[1] <= in_ch.sample_right;
          res_q[0]  <= in_ch.sample_left;
          res_q[1]  <= in_ch.sample_right;
          red_q     <= '0;
        end
      skpc_pkg::ST_ENV_MUL: begin
        envprod_q <= envprod_w;
        envneg_q  <= diff_w[16];
      end
      skpc_pkg::ST_KNEE: begin
        x2_q <= xs_w[13:0];
        if (below_w) red_q <= '0;
        else if (above_w) red_q <= sat_red(27'(ap_w[32:16]));
      end
      skpc_pkg::ST_KNEE_SQ: sq_q  <= 28'(x2_q) * 28'(x2_q);
      skpc_pkg::ST_KNEE_T:  t_q   <= tp_w[43:16];
      skpc_pkg::ST_KNEE_R:  red_q <= sat_red(rp_w[52:26]);
      skpc_pkg::ST_APPLY: begin
        res_q[0] <= lane_res_w[0];
        res_q[1] <= lane_res_w[1];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= res_q[0];
      out_right_q <= (CHANNELS > 1) ? res_q[1] : '0;
      out_red_q   <= red_q;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.out_left     = out_left_q;
  assign out_ch.out_right    = out_right_q;
  assign out_ch.reduction_db = out_red_q;

endmodule
`default_nettype wire

@@ rtl/core/skpc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skpc_checker: port-level checks of the compressor
// Output beat stability, one frame at a time, reduction range.
// ----------------------------------------------------------------------------
module skpc_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] out_left_i,
  input wire logic [SAMPLE_BITS-1:0] out_right_i,
  input wire logic [14:0]            out_red_i
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_left_i) && $stable(out_right_i)
                                    && $stable(out_red_i))
    else $error("result payload changed while stalled");

  // one frame in flight: input closes after a beat
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second frame taken while one is in flight");

  // reduction never exceeds the floor
  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_red_i <= skpc_pkg::FloorDb)
    else $error("reduction above 100 dB");

endmodule

bind soft_knee_peak_compressor_top skpc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_left_i  (out_ch.out_left),
  .out_right_i (out_ch.out_right),
  .out_red_i   (out_ch.reduction_db)
);
`default_nettype wire

@@ verif/skpc_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpc_tb_if: compile unit marker for the compressor bench
// The channel interfaces come from the RTL file; this file holds the bench
// package with the directed stimulus row type.
// ----------------------------------------------------------------------------
package skpc_tb_pkg;

  // one directed stimulus row; has_gold marks rows with a typed-in result
  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic               has_gold;
    logic signed [23:0] gold_left;
    logic signed [23:0] gold_right;
    logic [14:0]        gold_red;
  } frame_row_t;
endpackage

@@ verif/soft_knee_peak_compressor_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_knee_peak_compressor_top_tb: self-checking bench of the compressor
// Drives stereo frames through several register settings, predicts every
// result with a bit-true model of the detector, envelope, knee and gain,
// and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module soft_knee_peak_compressor_top_tb;

  localparam int unsigned SB = 24;
  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  skpc_in_if  #(.SAMPLE_BITS(SB)) in_ch();
  skpc_out_if #(.SAMPLE_BITS(SB)) out_ch();
  skpc_cfg_if                     cfg_ch();

  soft_knee_peak_compressor_top #(.CHANNELS(2), .SAMPLE_BITS(SB)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and shadow registers
  logic               m_enable;
  logic signed [15:0] m_thresh;
  logic [15:0]        m_slope, m_makeup, m_attack, m_release;
  logic [12:0]        m_knee;
  logic [23:0]        m_recip;
  logic signed [15:0] m_env;
  longint unsigned    gain_tab [17];

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [14:0]        red;
  } result_t;

  result_t     pending_results [$];
  int          errors = 0;
  int          frames_sent = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          sink_stall = 0;
  bit          hold_off = 1'b0;
  bit          sink_rand = 1'b1;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // level of the linked peak in dB Q8.8
  function automatic int peak_db(longint unsigned p);
    longint unsigned full, m, frac, lg, mag;
    int e;
    full = longint'(SB - 1) << 16;
    if (p == 0) return -25600;
    e = 0;
    while (e < 63 && (p >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (p >> (e - 30)) : (p << (30 - e));
    frac = 0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    lg = (longint'(e) << 16) | frac;
    if (lg >= full) return 0;
    mag = ((full - lg) * 64'd394566 + (64'd1 << 23)) >> 24;
    if (mag > 25600) mag = 25600;
    return -int'(mag);
  endfunction

  function automatic longint unsigned knee_reduction(int over);
    longint twice, kn;
    longint unsigned r, x2, t;
    twice = 2 * longint'(over);
    kn = longint'(m_knee);
    if (twice <= -kn) r = 0;
    else if (twice >= kn) r = (longint'(over) * m_slope + 32768) >> 16;
    else begin
      x2 = twice + kn;
      t = (x2 * x2 * m_slope) >> 16;
      r = (t * m_recip + (64'd1 << 25)) >> 26;
    end
    return (r > 25600) ? 25600 : r;
  endfunction

  function automatic longint sat_gain(longint s, longint unsigned gm);
    longint unsigned mag, prod;
    longint r;
    mag = (s < 0) ? -s : s;
    prod = (mag * gm + (64'd1 << 27)) >> 28;
    if (prod > 64'd8388608) prod = 64'd8388608;
    r = (s < 0) ? -longint'(prod) : longint'(prod);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r;
  endfunction

  // compress one frame, updating the envelope
  function automatic result_t compress_frame(logic signed [23:0] l, logic signed [23:0] r);
    result_t res;
    longint sl, sr, ex, g, gm;
    longint unsigned pk, red, stp;
    int level, diff, coeff;
    sl = l;
    sr = r;
    pk = (sl < 0) ? -sl : sl;
    if (((sr < 0) ? -sr : sr) > pk) pk = (sr < 0) ? -sr : sr;
    res.left = l;
    res.right = r;
    res.red = '0;
    if (m_enable) begin
      level = peak_db(pk);
      coeff = (level > int'(m_env)) ? m_attack : m_release;
      diff = level - int'(m_env);
      stp = (longint'(65536 - coeff) * ((diff < 0) ? -diff : diff) + 65535) >> 16;
      m_env = (diff < 0) ? m_env - int'(stp) : m_env + int'(stp);
      red = knee_reduction(int'(m_env) - int'(m_thresh));
      ex = (longint'(red) * 64'd2786635 + 32768) >> 16;
      g = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if ((ex >> (16 - k)) & 1) g = (g * gain_tab[k]) >> 30;
      g = ((ex >> 16) < 31) ? (g >> (ex >> 16)) : 0;
      gm = (g * m_makeup) >> 16;
      res.left = sat_gain(sl, gm);
      res.right = sat_gain(sr, gm);
      res.red = red[14:0];
    end
    return res;
  endfunction

  // configuration write, mirrored into the predictor
  task automatic write_reg(skpc_pkg::reg_idx_e idx, logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      skpc_pkg::REG_ENABLE:        m_enable  = val[0];
      skpc_pkg::REG_THRESHOLD_DB:  m_thresh  = {val[14], val[14:0]};
      skpc_pkg::REG_SLOPE:         m_slope   = val[15:0];
      skpc_pkg::REG_MAKEUP_GAIN:   m_makeup  = val[15:0];
      skpc_pkg::REG_KNEE_DB:       m_knee    = val[12:0];
      skpc_pkg::REG_KNEE_RECIP:    m_recip   = val;
      skpc_pkg::REG_ATTACK_COEFF:  m_attack  = val[15:0];
      default:                     m_release = val[15:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return;
    else if (roll < 92) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    else repeat ($urandom_range(20, 120)) @(posedge clk_i);
  endtask

  // send one frame; expected result queued at acceptance
  task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r,
                            bit gold, result_t gold_res);
    result_t res;
    in_ch.valid        <= 1'b1;
    in_ch.sample_left  <= l;
    in_ch.sample_right <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    res = compress_frame(l, r);
    if (gold && (res.left !== gold_res.left || res.right !== gold_res.right ||
                 res.red !== gold_res.red)) begin
      errors++;
      if (errors <= 10)
        $display("predictor disagrees with typed result %0d/%0d/%0d", gold_res.left,
                 gold_res.right, gold_res.red);
    end
    pending_results.push_back(gold ? gold_res : res);
    frames_sent++;
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      random_gap();
    end
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 255)) - 128);
      3: return 24'(int'($urandom_range(0, 32767)) - 16384);
      default: return 24'($urandom());
    endcase
  endfunction

  // result checking
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (want.left !== out_ch.out_left || want.right !== out_ch.out_right ||
            want.red !== out_ch.reduction_db) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d red %0d, got %0d %0d red %0d",
                     want.left, want.right, want.red, out_ch.out_left,
                     out_ch.out_right, out_ch.reduction_db);
        end
      end
    end
  end

  // receiver stalls: mostly short, a few long, or held off for a long stretch
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (!sink_rand) begin
      out_ch.ready <= 1'b1;
    end else if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else if ($urandom_range(0, 99) < 2) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= int'($urandom_range(20, 120));
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_off || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    skpc_tb_pkg::frame_row_t rows [$];
    result_t gold_res;
    in_ch.valid = 1'b0;
    in_ch.sample_left = '0;
    in_ch.sample_right = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = skpc_pkg::REG_ENABLE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    gain_tab[0] = 64'd1 << 30;
    gain_tab[1] = isqrt(64'd1 << 59);
    for (int k = 2; k <= 16; k++) gain_tab[k] = isqrt(gain_tab[k-1] << 30);
    m_enable = 0; m_thresh = -1536; m_slope = 0; m_makeup = 16384;
    m_knee = 1536; m_recip = 5461; m_attack = 65365; m_release = 65526;
    m_env = -25600;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: disabled after reset passes frames unchanged
    rows.push_back('{24'sh7FFFFF, 24'sh800000, 1, 24'sh7FFFFF, 24'sh800000, 0});
    rows.push_back('{24'sh000000, 24'sh000000, 1, 24'sh000000, 24'sh000000, 0});
    rows.push_back('{24'sh000001, -24'sh1, 1, 24'sh000001, -24'sh1, 0});
    foreach (rows[i]) begin
      gold_res = '{rows[i].gold_left, rows[i].gold_right, rows[i].gold_red};
      send_frame(rows[i].left, rows[i].right, rows[i].has_gold, gold_res);
    end
    in_ch.valid <= 1'b0;
    settle();

    // directed: enabled, hard compression, fast envelope, knee and extremes
    write_reg(skpc_pkg::REG_ENABLE, 1);
    write_reg(skpc_pkg::REG_SLOPE, 24'h00FFFF);
    write_reg(skpc_pkg::REG_ATTACK_COEFF, 0);
    write_reg(skpc_pkg::REG_RELEASE_COEFF, 0);
    write_reg(skpc_pkg::REG_THRESHOLD_DB, 24'h007A00);
    rows.delete();
    rows.push_back('{24'sh7FFFFF, 24'sh000000, 0, 0, 0, 0});
    rows.push_back('{24'sh800000, 24'sh800000, 0, 0, 0, 0});
    rows.push_back('{24'sh000000, 24'sh000000, 0, 0, 0, 0});
    rows.push_back('{24'sh000001, 24'sh7FFFFF, 0, 0, 0, 0});
    rows.push_back('{24'sh100000, -24'sh100000, 0, 0, 0, 0});
    rows.push_back('{24'sh040000, 24'sh020000, 0, 0, 0, 0});
    rows.push_back('{24'sh555555, -24'sh2AAAAA, 0, 0, 0, 0});
    foreach (rows[i]) send_frame(rows[i].left, rows[i].right, 0, gold_res);
    in_ch.valid <= 1'b0;
    settle();
    write_reg(skpc_pkg::REG_KNEE_DB, 0);
    write_reg(skpc_pkg::REG_MAKEUP_GAIN, 24'h00FFFF);
    write_reg(skpc_pkg::REG_THRESHOLD_DB, 24'h004E00);
    foreach (rows[i]) send_frame(rows[i].right, rows[i].left, 0, gold_res);
    in_ch.valid <= 1'b0;
    settle();
    write_reg(skpc_pkg::REG_KNEE_DB, 24'd6144);
    write_reg(skpc_pkg::REG_KNEE_RECIP, 24'hFFFFFF);
    write_reg(skpc_pkg::REG_MAKEUP_GAIN, 0);
    foreach (rows[i]) send_frame(rows[i].left, rows[i].left, 0, gold_res);
    in_ch.valid <= 1'b0;
    settle();

    // random phases, each under a fresh setting; one long receiver hold-off
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(skpc_pkg::REG_ENABLE, 24'((ph == 3) ? 0 : 1));
      write_reg(skpc_pkg::REG_THRESHOLD_DB,
                24'((ph == 0) ? 0 : -int'($urandom_range(0, 12800))));
      write_reg(skpc_pkg::REG_SLOPE, 24'((ph == 1) ? 0 : $urandom_range(0, 65535)));
      write_reg(skpc_pkg::REG_MAKEUP_GAIN, 24'($urandom_range(0, 65535)));
      write_reg(skpc_pkg::REG_KNEE_DB, 24'((ph == 2) ? 0 : $urandom_range(0, 6144)));
      write_reg(skpc_pkg::REG_KNEE_RECIP,
                (ph == 4) ? 24'hFFFFFF : 24'($urandom_range(0, 40000)));
      write_reg(skpc_pkg::REG_ATTACK_COEFF,
                (ph == 5) ? 24'h00FFFF : 24'($urandom_range(0, 65535)));
      write_reg(skpc_pkg::REG_RELEASE_COEFF, 24'($urandom_range(60000, 65535)));
      sink_rand = (ph != 6);
      if (ph == 2) fork
        begin
          @(posedge clk_i);
          hold_off = 1'b1;
          repeat (400) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      for (int n = 0; n < 95; n++) send_frame(rand_sample(), rand_sample(), 0, gold_res);
      in_ch.valid <= 1'b0;
      settle();
    end

    $display("covered %0d frames and %0d results over disabled, hard-knee, soft-knee",
             frames_sent, results_seen);
    $display("and random register settings, with a long output hold-off");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
